// ===== hdl/magnetometer_minmax_calibration_unit_defines.svh =====
// Assertion macros used by the checker file of the calibration unit.
`ifndef MAGNETOMETER_MINMAX_CALIBRATION_UNIT_DEFINES_SVH
`define MAGNETOMETER_MINMAX_CALIBRATION_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_pkg
// Widths, register indexes, microcode encoding and program of the
// magnetometer min/max calibration unit.
// ----------------------------------------------------------------------------
package mmc_pkg;

    localparam int AXES      = 3;
    localparam int DATA_W    = 16;
    localparam int GAIN_FRAC = 14;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SHIFT_W   = PROD_W - GAIN_FRAC;
    localparam int SUM_W     = DATA_W + 2;
    localparam int NUM_W     = SUM_W + GAIN_FRAC;
    localparam int DEN_W     = SUM_W;
    localparam int QUOT_W    = DATA_W;
    localparam int DSH_W     = DEN_W + QUOT_W - 1;
    localparam int ITER_W    = 4;
    localparam int STEP_W    = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_GAIN   = 3'd5;

    localparam logic [DATA_W-1:0] GAIN_ONE = 16'd16384;

    // Datapath operations.
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_WAIT_IN   = 4'd1;
    localparam logic [3:0] OP_MUL       = 4'd2;
    localparam logic [3:0] OP_CORR      = 4'd3;
    localparam logic [3:0] OP_SUM       = 4'd4;
    localparam logic [3:0] OP_DIV_LOAD  = 4'd5;
    localparam logic [3:0] OP_DIV_STEP  = 4'd6;
    localparam logic [3:0] OP_DIV_STORE = 4'd7;
    localparam logic [3:0] OP_EMIT      = 4'd8;

    // Jump conditions.
    localparam logic [2:0] JC_NEXT     = 3'd0;
    localparam logic [2:0] JC_NO_IN    = 3'd1;
    localparam logic [2:0] JC_ITER     = 3'd2;
    localparam logic [2:0] JC_OUT_BUSY = 3'd3;
    localparam logic [2:0] JC_ALWAYS   = 3'd4;

    localparam logic [AXIS_W-1:0] AX_X = 2'd0;
    localparam logic [AXIS_W-1:0] AX_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AX_Z = 2'd2;

    // Program addresses that are jump targets.
    localparam logic [STEP_W-1:0] STEP_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] STEP_DIV_X = 5'd9;
    localparam logic [STEP_W-1:0] STEP_DIV_Y = 5'd12;
    localparam logic [STEP_W-1:0] STEP_DIV_Z = 5'd15;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 5'd17;

    typedef struct packed {
        logic [3:0]        op;
        logic [AXIS_W-1:0] axis;
        logic [2:0]        jc;
        logic [STEP_W-1:0] target;
    } t_uword;

    function automatic t_uword uw(input logic [3:0] op, input logic [AXIS_W-1:0] axis,
                                  input logic [2:0] jc, input logic [STEP_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.axis   = axis;
        w.jc     = jc;
        w.target = target;
        return w;
    endfunction

    // Control store: one word per step.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            5'd0:    w = uw(OP_WAIT_IN,   AX_X, JC_NO_IN,    STEP_IDLE);
            5'd1:    w = uw(OP_MUL,       AX_X, JC_NEXT,     STEP_IDLE);
            5'd2:    w = uw(OP_CORR,      AX_X, JC_NEXT,     STEP_IDLE);
            5'd3:    w = uw(OP_MUL,       AX_Y, JC_NEXT,     STEP_IDLE);
            5'd4:    w = uw(OP_CORR,      AX_Y, JC_NEXT,     STEP_IDLE);
            5'd5:    w = uw(OP_MUL,       AX_Z, JC_NEXT,     STEP_IDLE);
            5'd6:    w = uw(OP_CORR,      AX_Z, JC_NEXT,     STEP_IDLE);
            5'd7:    w = uw(OP_SUM,       AX_X, JC_NEXT,     STEP_IDLE);
            5'd8:    w = uw(OP_DIV_LOAD,  AX_X, JC_NEXT,     STEP_IDLE);
            5'd9:    w = uw(OP_DIV_STEP,  AX_X, JC_ITER,     STEP_DIV_X);
            5'd10:   w = uw(OP_DIV_STORE, AX_X, JC_NEXT,     STEP_IDLE);
            5'd11:   w = uw(OP_DIV_LOAD,  AX_Y, JC_NEXT,     STEP_IDLE);
            5'd12:   w = uw(OP_DIV_STEP,  AX_Y, JC_ITER,     STEP_DIV_Y);
            5'd13:   w = uw(OP_DIV_STORE, AX_Y, JC_NEXT,     STEP_IDLE);
            5'd14:   w = uw(OP_DIV_LOAD,  AX_Z, JC_NEXT,     STEP_IDLE);
            5'd15:   w = uw(OP_DIV_STEP,  AX_Z, JC_ITER,     STEP_DIV_Z);
            5'd16:   w = uw(OP_DIV_STORE, AX_Z, JC_NEXT,     STEP_IDLE);
            5'd17:   w = uw(OP_EMIT,      AX_X, JC_OUT_BUSY, STEP_EMIT);
            default: w = uw(OP_NOP,       AX_X, JC_ALWAYS,   STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/mmc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_if
// Handshake channels of the calibration unit: sample in, result out and
// register write.
// ----------------------------------------------------------------------------
interface mmc_in_if import mmc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] raw_x;
    logic signed [DATA_W-1:0] raw_y;
    logic signed [DATA_W-1:0] raw_z;

    modport source (output valid, raw_x, raw_y, raw_z, input ready);
    modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface mmc_out_if import mmc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] corr_x;
    logic signed [DATA_W-1:0] corr_y;
    logic signed [DATA_W-1:0] corr_z;
    logic signed [DATA_W-1:0] centre_x;
    logic signed [DATA_W-1:0] centre_y;
    logic signed [DATA_W-1:0] centre_z;
    logic        [DATA_W-1:0] gain_x;
    logic        [DATA_W-1:0] gain_y;
    logic        [DATA_W-1:0] gain_z;
    logic                     gains_valid;

    modport source (output valid, corr_x, corr_y, corr_z, centre_x, centre_y, centre_z,
                    gain_x, gain_y, gain_z, gains_valid, input ready);
    modport sink   (input valid, corr_x, corr_y, corr_z, centre_x, centre_y, centre_z,
                    gain_x, gain_y, gain_z, gains_valid, output ready);
endinterface

interface mmc_cfg_if import mmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/magnetometer_minmax_calibration_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration_unit
// Offset and gain correction of three-axis magnetometer samples with running
// min/max tracking, hard-iron centre and soft-iron gain estimation.
// ----------------------------------------------------------------------------
// Usage:
// i_in carries one raw three-axis sample per word. o_out carries one result
// word per sample: corrected axes, per-axis centre, per-axis gain and a flag
// that is set when all three ranges are nonzero. i_cfg writes the six
// registers (three offsets, three Q2.14 gain presets); it is always ready.
// A microcoded sequencer runs its program over a single multiplier and a
// radix-2 restoring divider, one sample at a time: i_in is ready again in
// the cycle after the result word of the last sample appears on o_out.
// Most of the program goes to the three 16-iteration divides.
// Reset clears the min/max trackers to zero, the offsets to zero and the
// gain presets to 1.0. The output register holds a finished result while
// the receiver stalls; the sequencer can still take and work one more
// sample, then waits in its emit step until that word has left.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibration_unit
    import mmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mmc_in_if.sink    i_in,
    mmc_cfg_if.sink   i_cfg,
    mmc_out_if.source o_out
);

    // Sequencer.
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            w;
    logic              in_acc;
    logic              out_free;
    logic              jump;

    // Configuration.
    logic signed [DATA_W-1:0] r_off  [AXES];
    logic        [DATA_W-1:0] r_gpre [AXES];
    logic        [CFG_IDX_W-1:0] cfg_gidx;

    // Working registers.
    logic signed [DATA_W-1:0] r_raw    [AXES];
    logic signed [DATA_W-1:0] r_corr   [AXES];
    logic signed [DATA_W-1:0] r_max    [AXES];
    logic signed [DATA_W-1:0] r_min    [AXES];
    logic        [DATA_W-1:0] r_range  [AXES];
    logic signed [DATA_W-1:0] r_centre [AXES];
    logic        [DATA_W-1:0] r_gain   [AXES];
    logic        [SUM_W-1:0]  r_sum;
    logic                     r_valid;
    logic signed [PROD_W-1:0] r_prod;

    // Divider.
    logic [NUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [QUOT_W-1:0] r_quot;
    logic [ITER_W-1:0] r_iter;
    logic              r_dsat;
    logic              r_dzero;

    // Output register.
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_o_corr   [AXES];
    logic signed [DATA_W-1:0] r_o_centre [AXES];
    logic        [DATA_W-1:0] r_o_gain   [AXES];
    logic                     r_o_gvalid;

    // Combinational datapath values.
    logic signed [DIFF_W-1:0]  diff_c;
    logic signed [DIFF_W-1:0]  gain_s;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [SHIFT_W-1:0] sh_c;
    logic signed [DATA_W-1:0]  corr_c;
    logic [DATA_W-1:0]         rng_c  [AXES];
    logic signed [DATA_W:0]    mid_c  [AXES];
    logic [SUM_W-1:0]          sum_c;
    logic [DEN_W-1:0]          den_c;
    logic [NUM_W-1:0]          num_c;
    logic                      ge_c;

    assign w        = ucode(r_step);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (w.op == OP_WAIT_IN);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        unique case (w.jc)
            JC_NO_IN:    jump = !in_acc;
            JC_ITER:     jump = (r_iter != '0);
            JC_OUT_BUSY: jump = !out_free;
            JC_ALWAYS:   jump = 1'b1;
            default:     jump = 1'b0;
        endcase
        n_step = jump ? w.target : r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Register writes. Indexes past the last register are ignored.
    assign cfg_gidx = i_cfg.index - REG_X_GAIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_off[a]  <= '0;
                r_gpre[a] <= GAIN_ONE;
            end
        end else if (i_cfg.valid && i_cfg.ready) begin
            priority if (i_cfg.index <= REG_Z_OFFSET) begin
                r_off[i_cfg.index[AXIS_W-1:0]] <= i_cfg.data;
            end else if (i_cfg.index <= REG_Z_GAIN) begin
                r_gpre[cfg_gidx[AXIS_W-1:0]] <= i_cfg.data;
            end else begin
                r_off[AXIS_W'(0)] <= r_off[AXIS_W'(0)];
            end
        end
    end

    // Correction: one axis through the multiplier, then shift and saturate.
    always_comb begin
        diff_c = {r_raw[w.axis][DATA_W-1], r_raw[w.axis]}
               - {r_off[w.axis][DATA_W-1], r_off[w.axis]};
        gain_s = {1'b0, r_gpre[w.axis]};
        prod_c = diff_c * gain_s;
        sh_c   = r_prod[PROD_W-1:GAIN_FRAC];
        // The shifted value fits when its top bits are all sign copies.
        if (sh_c[SHIFT_W-1:DATA_W-1] == '0 || sh_c[SHIFT_W-1:DATA_W-1] == '1) begin
            corr_c = sh_c[DATA_W-1:0];
        end else begin
            corr_c = {sh_c[SHIFT_W-1], {(DATA_W-1){!sh_c[SHIFT_W-1]}}};
        end
    end

    // Ranges, their sum and the centres. The maximum never drops below zero
    // and the minimum never rises above it, so the range is never negative.
    always_comb begin
        sum_c = '0;
        for (int a = 0; a < AXES; a++) begin
            rng_c[a] = r_max[a] - r_min[a];
            mid_c[a] = {r_max[a][DATA_W-1], r_max[a]} + {r_min[a][DATA_W-1], r_min[a]};
            sum_c    = sum_c + SUM_W'(rng_c[a]);
        end
    end

    // Divider setup: the quotient saturates when it would need more than
    // 16 bits, otherwise 16 restoring steps produce it.
    always_comb begin
        den_c = DEN_W'(r_range[w.axis]) + DEN_W'({r_range[w.axis], 1'b0});
        num_c = {r_sum, {GAIN_FRAC{1'b0}}};
        ge_c  = {1'b0, r_rem} >= r_dsh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_max[a] <= '0;
                r_min[a] <= '0;
            end
        end else begin
            unique case (w.op)
                OP_WAIT_IN: begin
                    if (in_acc) begin
                        r_raw[AX_X] <= i_in.raw_x;
                        r_raw[AX_Y] <= i_in.raw_y;
                        r_raw[AX_Z] <= i_in.raw_z;
                    end
                end
                OP_MUL: begin
                    r_prod <= prod_c;
                end
                OP_CORR: begin
                    r_corr[w.axis] <= corr_c;
                    // A new maximum wins over a new minimum.
                    if (corr_c >= r_max[w.axis]) begin
                        r_max[w.axis] <= corr_c;
                    end else if (corr_c <= r_min[w.axis]) begin
                        r_min[w.axis] <= corr_c;
                    end
                end
                OP_SUM: begin
                    for (int a = 0; a < AXES; a++) begin
                        r_range[a]  <= rng_c[a];
                        r_centre[a] <= mid_c[a][DATA_W:1];
                    end
                    r_sum   <= sum_c;
                    r_valid <= (rng_c[AX_X] != '0) && (rng_c[AX_Y] != '0)
                            && (rng_c[AX_Z] != '0);
                end
                OP_DIV_LOAD: begin
                    r_rem   <= num_c;
                    r_dsh   <= {den_c, {(QUOT_W-1){1'b0}}};
                    r_quot  <= '0;
                    r_iter  <= '1;
                    r_dzero <= (r_range[w.axis] == '0);
                    r_dsat  <= {2'b0, num_c} >= {den_c, {QUOT_W{1'b0}}};
                end
                OP_DIV_STEP: begin
                    if (ge_c) begin
                        r_rem <= r_rem - r_dsh[NUM_W-1:0];
                    end
                    r_quot <= {r_quot[QUOT_W-2:0], ge_c};
                    r_dsh  <= r_dsh >> 1;
                    r_iter <= r_iter - ITER_W'(1);
                end
                OP_DIV_STORE: begin
                    priority if (r_dzero) begin
                        r_gain[w.axis] <= '0;
                    end else if (r_dsat) begin
                        r_gain[w.axis] <= '1;
                    end else begin
                        r_gain[w.axis] <= r_quot;
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w.op == OP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w.op == OP_EMIT && out_free) begin
            r_o_corr   <= r_corr;
            r_o_centre <= r_centre;
            r_o_gain   <= r_gain;
            r_o_gvalid <= r_valid;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.corr_x      = r_o_corr[AX_X];
    assign o_out.corr_y      = r_o_corr[AX_Y];
    assign o_out.corr_z      = r_o_corr[AX_Z];
    assign o_out.centre_x    = r_o_centre[AX_X];
    assign o_out.centre_y    = r_o_centre[AX_Y];
    assign o_out.centre_z    = r_o_centre[AX_Z];
    assign o_out.gain_x      = r_o_gain[AX_X];
    assign o_out.gain_y      = r_o_gain[AX_Y];
    assign o_out.gain_z      = r_o_gain[AX_Z];
    assign o_out.gains_valid = r_o_gvalid;

endmodule

// ===== hdl/mmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_checker
// Port-level checks of the calibration unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "magnetometer_minmax_calibration_unit_defines.svh"

module mmc_checker
    import mmc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_corr_x,
    input logic [DATA_W-1:0] i_gain_x,
    input logic [DATA_W-1:0] i_gain_y,
    input logic [DATA_W-1:0] i_gain_z,
    input logic              i_gains_valid
);

    // A stalled result word stays put.
    `MMC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_corr_x) && $stable(i_gain_x), "result changed while stalled")

    // Samples are worked one at a time: the input closes right after a take.
    `MMC_ASSERT_NEXT(a_in_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready,
        !i_in_ready, "input still open after a sample was taken")

    // A nonzero range always yields a gain of at least one third, so the
    // flag matches exactly the gains that are zero.
    `MMC_ASSERT_NOW(a_gains_flag, i_clk, i_rst_n, i_out_valid,
        i_gains_valid == (i_gain_x != '0 && i_gain_y != '0 && i_gain_z != '0),
        "gains_valid disagrees with the gains")

endmodule

bind magnetometer_minmax_calibration_unit mmc_checker u_mmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_corr_x      (o_out.corr_x),
    .i_gain_x      (o_out.gain_x),
    .i_gain_y      (o_out.gain_y),
    .i_gain_z      (o_out.gain_z),
    .i_gains_valid (o_out.gains_valid)
);

// ===== tb/tb_magnetometer_minmax_calibration_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_magnetometer_minmax_calibration_unit
// Drives raw three-axis samples through the calibration unit under changing
// offset and gain settings and compares each result word against a local
// model of the correction, min/max tracking, centre and gain arithmetic.
// ----------------------------------------------------------------------------
module tb_magnetometer_minmax_calibration_unit;
    import mmc_pkg::*;

    localparam int RANDOM_PHASES     = 10;
    localparam int SAMPLES_PER_PHASE = 170;
    localparam int TAIL_CYCLES       = 80;
    localparam int LIMIT_NS          = 8_000_000;
    localparam int MAX_WAIT          = 6;
    localparam int REPORT_LIMIT      = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_OFFSET,
        CFG_Y_OFFSET,
        CFG_Z_OFFSET,
        CFG_X_GAIN,
        CFG_Y_GAIN,
        CFG_Z_GAIN
    } t_cfg_reg;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } t_sample;

    typedef struct packed {
        logic signed [DATA_W-1:0] corr_x;
        logic signed [DATA_W-1:0] corr_y;
        logic signed [DATA_W-1:0] corr_z;
        logic signed [DATA_W-1:0] centre_x;
        logic signed [DATA_W-1:0] centre_y;
        logic signed [DATA_W-1:0] centre_z;
        logic        [DATA_W-1:0] gain_x;
        logic        [DATA_W-1:0] gain_y;
        logic        [DATA_W-1:0] gain_z;
        logic                     gains_valid;
    } t_calib_result;

    logic                 i_clk;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_sample              in_word   = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 out_ready = 1'b0;
    logic                 sender_calm   = 1'b0;
    logic                 receiver_calm = 1'b0;

    // Local copy of the block's registers and trackers.
    logic signed [DATA_W-1:0] axis_offset      [AXES];
    logic        [DATA_W-1:0] axis_gain_preset [AXES];
    logic signed [DATA_W-1:0] axis_max         [AXES];
    logic signed [DATA_W-1:0] axis_min         [AXES];

    t_sample       pending_samples [$];
    t_calib_result due_calibrations [$];
    int            mismatch_count = 0;
    int            sample_gap     = 0;
    int            result_stall   = 0;

    mmc_in_if  in_if ();
    mmc_cfg_if cfg_if ();
    mmc_out_if out_if ();

    assign in_if.valid   = in_valid;
    assign in_if.raw_x   = in_word.x;
    assign in_if.raw_y   = in_word.y;
    assign in_if.raw_z   = in_word.z;
    assign cfg_if.valid  = cfg_valid;
    assign cfg_if.index  = cfg_index;
    assign cfg_if.data   = cfg_data;
    assign out_if.ready  = out_ready;

    magnetometer_minmax_calibration_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int a = 0; a < AXES; a++) begin
            axis_offset[a]      = '0;
            axis_gain_preset[a] = GAIN_ONE;
            axis_max[a]         = '0;
            axis_min[a]         = '0;
        end
    end

    function automatic int draw_wait(input logic calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_sample make_sample(input int x, input int y, input int z);
        t_sample s;
        s.x = DATA_W'(x);
        s.y = DATA_W'(y);
        s.z = DATA_W'(z);
        return s;
    endfunction

    // Corrects one sample, updates the trackers and forms centre and gains.
    function automatic t_calib_result compute_calibration(input t_sample s);
        logic signed [DATA_W-1:0] raw    [AXES];
        logic signed [DATA_W-1:0] corr   [AXES];
        logic signed [DATA_W-1:0] centre [AXES];
        logic        [DATA_W-1:0] gain   [AXES];
        longint                   diff;
        longint                   scaled;
        longint unsigned          span   [AXES];
        longint unsigned          span_sum;
        longint unsigned          quot;
        logic                     all_nonzero;
        t_calib_result            r;
        int                       a;
        raw[0] = s.x;
        raw[1] = s.y;
        raw[2] = s.z;
        span_sum    = 0;
        all_nonzero = 1'b1;
        for (a = 0; a < AXES; a++) begin
            diff   = longint'(raw[a]) - longint'(axis_offset[a]);
            // Arithmetic shift of a signed product floors toward minus infinity.
            scaled = (diff * longint'(axis_gain_preset[a])) >>> GAIN_FRAC;
            if (scaled > 32767) begin
                scaled = 32767;
            end else if (scaled < -32768) begin
                scaled = -32768;
            end
            corr[a] = DATA_W'(scaled);
            if (corr[a] >= axis_max[a]) begin
                axis_max[a] = corr[a];
            end else if (corr[a] <= axis_min[a]) begin
                axis_min[a] = corr[a];
            end
            span[a]   = longint'(axis_max[a]) - longint'(axis_min[a]);
            span_sum += span[a];
        end
        for (a = 0; a < AXES; a++) begin
            if (span[a] == 0) begin
                gain[a]     = '0;
                all_nonzero = 1'b0;
            end else begin
                quot    = (span_sum << GAIN_FRAC) / (3 * span[a]);
                gain[a] = (quot > 65535) ? 16'hFFFF : quot[DATA_W-1:0];
            end
            centre[a] = DATA_W'((int'(axis_max[a]) + int'(axis_min[a])) >>> 1);
        end
        r.corr_x      = corr[0];
        r.corr_y      = corr[1];
        r.corr_z      = corr[2];
        r.centre_x    = centre[0];
        r.centre_y    = centre[1];
        r.centre_z    = centre[2];
        r.gain_x      = gain[0];
        r.gain_y      = gain[1];
        r.gain_z      = gain[2];
        r.gains_valid = all_nonzero;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
        mismatch_count++;
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got, input bit is_signed);
        if (got !== want) begin
            if (is_signed) begin
                note_failure($sformatf("%s mismatch: expected %0d, got %0d",
                                       name, $signed(want), $signed(got)));
            end else begin
                note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
            end
        end
    endfunction

    // Sample driver: after each accepted word it holds off for a drawn number
    // of cycles in which the block is waiting for input.
    always @(posedge i_clk) begin : sample_driver
        logic offer;
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            sample_gap = 0;
        end else begin
            offer = in_valid;
            if (in_valid && in_if.ready) begin
                due_calibrations.push_back(compute_calibration(in_word));
                offer      = 1'b0;
                sample_gap = draw_wait(sender_calm);
            end
            if (!offer && pending_samples.size() > 0) begin
                if (sample_gap > 0) begin
                    if (in_if.ready) begin
                        sample_gap--;
                    end
                end else begin
                    in_word <= pending_samples.pop_front();
                    offer   = 1'b1;
                end
            end
            in_valid <= offer;
        end
    end

    // Result monitor: the stall after each word only counts down while a
    // result is on offer, so the block really sees back pressure.
    always @(posedge i_clk) begin : result_monitor
        t_calib_result got;
        t_calib_result want;
        if (!i_rst_n) begin
            out_ready    <= 1'b0;
            result_stall = 0;
        end else begin
            if (out_if.valid && out_ready) begin
                got.corr_x      = out_if.corr_x;
                got.corr_y      = out_if.corr_y;
                got.corr_z      = out_if.corr_z;
                got.centre_x    = out_if.centre_x;
                got.centre_y    = out_if.centre_y;
                got.centre_z    = out_if.centre_z;
                got.gain_x      = out_if.gain_x;
                got.gain_y      = out_if.gain_y;
                got.gain_z      = out_if.gain_z;
                got.gains_valid = out_if.gains_valid;
                if (due_calibrations.size() == 0) begin
                    note_failure("result word with no sample outstanding");
                end else begin
                    want = due_calibrations.pop_front();
                    check_field("corr_x",      want.corr_x,      got.corr_x,      1'b1);
                    check_field("corr_y",      want.corr_y,      got.corr_y,      1'b1);
                    check_field("corr_z",      want.corr_z,      got.corr_z,      1'b1);
                    check_field("centre_x",    want.centre_x,    got.centre_x,    1'b1);
                    check_field("centre_y",    want.centre_y,    got.centre_y,    1'b1);
                    check_field("centre_z",    want.centre_z,    got.centre_z,    1'b1);
                    check_field("gain_x",      want.gain_x,      got.gain_x,      1'b0);
                    check_field("gain_y",      want.gain_y,      got.gain_y,      1'b0);
                    check_field("gain_z",      want.gain_z,      got.gain_z,      1'b0);
                    check_field("gains_valid", DATA_W'(want.gains_valid),
                                DATA_W'(got.gains_valid), 1'b0);
                end
                result_stall = draw_wait(receiver_calm);
            end
            if (result_stall > 0) begin
                if (out_if.valid) begin
                    result_stall--;
                end
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_register(input t_cfg_reg reg_sel, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (reg_sel <= CFG_Z_OFFSET) begin
            axis_offset[reg_sel] = value;
        end else begin
            axis_gain_preset[reg_sel - CFG_X_GAIN] = value;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] offsets [AXES],
                                  input logic [DATA_W-1:0] presets [AXES]);
        for (int a = 0; a < AXES; a++) begin
            write_register(t_cfg_reg'(CFG_X_OFFSET + a), offsets[a]);
            write_register(t_cfg_reg'(CFG_X_GAIN + a), presets[a]);
        end
    endtask

    // Idle means nothing queued, nothing on offer and no result outstanding.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || in_valid || due_calibrations.size() != 0);
    endtask

    function automatic t_sample random_sample(input t_sample prev);
        logic [DATA_W-1:0] v [AXES];
        int                style;
        t_sample           s;
        style = $urandom_range(0, 9);
        if (style == 9) begin
            return prev;
        end
        for (int a = 0; a < AXES; a++) begin
            if (style <= 5) begin
                v[a] = DATA_W'($urandom);
            end else if (style <= 7) begin
                // Close to the offset, so the corrected value lands near zero.
                v[a] = axis_offset[a] + DATA_W'($urandom_range(0, 128)) - DATA_W'(64);
            end else begin
                case ($urandom_range(0, 3))
                    0:       v[a] = 16'h8000;
                    1:       v[a] = 16'hFFFF;
                    2:       v[a] = 16'h0000;
                    default: v[a] = 16'h7FFF;
                endcase
            end
        end
        s.x = v[0];
        s.y = v[1];
        s.z = v[2];
        return s;
    endfunction

    initial begin : stimulus
        logic [DATA_W-1:0] offsets [AXES];
        logic [DATA_W-1:0] presets [AXES];
        t_sample           prev;
        prev = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: the trackers grow from zero through zero ranges,
        // odd negative sums and a saturated gain.
        @(negedge i_clk);
        pending_samples.push_back(make_sample(0, 0, 0));
        pending_samples.push_back(make_sample(1, 0, 0));
        pending_samples.push_back(make_sample(0, -1, 0));
        pending_samples.push_back(make_sample(0, 0, -3));
        pending_samples.push_back(make_sample(1, -1, -3));
        pending_samples.push_back(make_sample(0, 20, 0));
        pending_samples.push_back(make_sample(-5, 0, 0));

        // Extreme offsets and presets drive the correction into saturation.
        wait_idle();
        apply_settings('{16'h8000, 16'h7FFF, 16'h0000}, '{16'hFFFF, 16'hFFFF, 16'h0000});
        @(negedge i_clk);
        pending_samples.push_back(make_sample(32767, -32768, 32767));
        pending_samples.push_back(make_sample(-32768, 32767, -32768));
        pending_samples.push_back(make_sample(0, 0, 0));

        // A preset of one exposes flooring of small negative products.
        wait_idle();
        apply_settings('{16'h0000, 16'h0000, 16'h0000}, '{16'h0001, 16'h0001, 16'h0001});
        @(negedge i_clk);
        pending_samples.push_back(make_sample(-1, 1, -32768));
        pending_samples.push_back(make_sample(32767, -32768, -1));

        wait_idle();
        apply_settings('{16'h7FFF, 16'h8000, 16'h3FFF}, '{GAIN_ONE, 16'h8000, 16'hC000});
        @(negedge i_clk);
        pending_samples.push_back(make_sample(-32768, 32767, -16384));
        pending_samples.push_back(make_sample(12345, -12345, 4321));
        pending_samples.push_back(make_sample(-1, -1, -1));

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            sender_calm   <= ($urandom_range(0, 3) == 0);
            receiver_calm <= ($urandom_range(0, 3) == 0);
            for (int a = 0; a < AXES; a++) begin
                case ($urandom_range(0, 3))
                    0:       offsets[a] = '0;
                    1:       offsets[a] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    default: offsets[a] = DATA_W'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:       presets[a] = GAIN_ONE;
                    1:       presets[a] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    2:       presets[a] = DATA_W'($urandom_range(8192, 24576));
                    default: presets[a] = DATA_W'($urandom);
                endcase
            end
            apply_settings(offsets, presets);
            @(negedge i_clk);
            for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
                prev = random_sample(prev);
                pending_samples.push_back(prev);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_calibrations.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", due_calibrations.size()));
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mmc_pkg.sv
hdl/mmc_if.sv
hdl/magnetometer_minmax_calibration_unit.sv
hdl/mmc_checker.sv
tb/tb_magnetometer_minmax_calibration_unit.sv
